### rtl/sbr_pkg.sv
// shared types and constants for the sbus frame receiver
`timescale 1ns / 1ps
package sbr_pkg;

	localparam int unsigned NumChannels = 16;
	localparam int unsigned ChanW       = 11;
	localparam int unsigned StoreLen    = 23;
	localparam int unsigned ChanBytes   = 22;
	localparam int unsigned TickW       = 11;
	localparam int unsigned TimeoutW    = 10;
	localparam int unsigned PosW        = 5;
	localparam int unsigned RemW        = 5;

	localparam logic [7:0] Header     = 8'h0F;
	localparam logic [7:0] FooterA    = 8'h00;
	localparam logic [7:0] FooterB    = 8'h04;
	localparam logic [7:0] FooterC    = 8'h08;
	localparam logic [PosW-1:0] PosIdle   = 5'd0;
	localparam logic [PosW-1:0] PosFooter = 5'd24;
	localparam logic [TickW-1:0] TickMax  = 11'd2047;
	localparam logic [TimeoutW-1:0] TimeoutReset = 10'd50;
	localparam logic [RemW-1:0] RunLen   = 5'd16;

	// item kinds
	localparam logic FuncByte = 1'b0;
	localparam logic FuncTick = 1'b1;
	localparam logic KindChannel = 1'b0;
	localparam logic KindTimeout = 1'b1;

	// control for one channel cell
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage

### rtl/sbr_byte_cell.sv
// one byte cell of the frame store shift chain
`timescale 1ns / 1ps
module sbr_byte_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] din,
	output logic [7:0] dout
);

	logic [7:0] byte_q;

	// take the neighbor's byte on each stored request
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;

endmodule

### rtl/sbr_chan_cell.sv
// one channel cell of the output run chain
`timescale 1ns / 1ps
module sbr_chan_cell (
	input  logic                      clk,
	input  sbr_pkg::cell_ctrl_t       ctrl,
	input  logic [sbr_pkg::ChanW-1:0] load_val,
	input  logic [sbr_pkg::ChanW-1:0] shift_in,
	output logic [sbr_pkg::ChanW-1:0] dout
);

	logic [sbr_pkg::ChanW-1:0] val_q;

	// load a fresh frame or hand the value one cell toward the output
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			val_q <= load_val;
		end else if (ctrl.shift) begin
			val_q <= shift_in;
		end
	end

	assign dout = val_q;

endmodule

### rtl/sbus_frame_receiver.sv
// sbus frame receiver: byte chain, channel unpack, output run chain, link timeout
//
// channel | handshake             | payload
// in      | in_valid / in_ready   | func, rx_data
// out     | out_valid / out_ready | kind, channel_index, channel_value,
//         |                       | frame_lost_flag, failsafe_flag, link_ok, last
// cfg     | cfg_valid / cfg_ready | timeout_ticks
//
// one input request per cycle while in_ready is high; a byte is stored by shifting the 23-cell
// byte chain. a good footer loads 16 channel cells at once; they shift out one per cycle while
// out_ready is high. a footer byte, or a tick that drops the link, waits until the run chain is
// empty or its last result is taken; the first result shows in the cycle after its request.
// reset clears position, link state, tick count and the run counter and sets the timeout
// to 50; cfg_ready is always high.
`timescale 1ns / 1ps
module sbus_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  rx_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [3:0]  channel_index,
	output logic [10:0] channel_value,
	output logic        frame_lost_flag,
	output logic        failsafe_flag,
	output logic        link_ok,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  timeout_ticks
);

	localparam int unsigned NCh = sbr_pkg::NumChannels;
	localparam int unsigned CW  = sbr_pkg::ChanW;
	localparam int unsigned SL  = sbr_pkg::StoreLen;

	logic [sbr_pkg::PosW-1:0]     pos_q;
	logic                         valid_q;
	logic [sbr_pkg::TickW-1:0]    ticks_q;
	logic [sbr_pkg::TimeoutW-1:0] timeout_q;
	logic [sbr_pkg::RemW-1:0]     rem_q;
	logic [3:0]                   idx_q;
	logic                         kind_q;
	logic                         lost_q;
	logic                         fs_q;
	logic                         ok_q;

	logic [7:0]    store [SL];
	logic [CW-1:0] chan  [NCh];
	logic [sbr_pkg::ChanBytes*8-1:0] packed_bytes;

	logic                      accept;
	logic                      take;
	logic                      slot_free;
	logic                      store_en;
	logic                      footer_ok;
	logic                      frame_emit;
	logic                      tick_emit;
	logic                      tick_over;
	logic [sbr_pkg::TickW-1:0] ticks_next;
	logic                      flag_lost;
	logic                      flag_fs;
	logic                      frame_ok;
	sbr_pkg::cell_ctrl_t       cell_ctrl;

	// handshake terms
	assign accept    = in_valid && in_ready;
	assign take      = out_valid && out_ready;
	assign slot_free = (rem_q == '0) || (rem_q == sbr_pkg::RemW'(1) && out_ready);
	assign cfg_ready = 1'b1;

	// tick counter next value and timeout compare
	assign ticks_next = (ticks_q == sbr_pkg::TickMax) ? ticks_q : ticks_q + 1'b1;
	assign tick_over  = ticks_next > {1'b0, timeout_q};

	// footer and flag decode
	always_comb begin
		footer_ok = rx_data inside {sbr_pkg::FooterA, sbr_pkg::FooterB, sbr_pkg::FooterC};
	end
	assign flag_lost = store[SL-1][2];
	assign flag_fs   = store[SL-1][3];
	assign frame_ok  = !flag_lost && !flag_fs;

	// only footer bytes and link-dropping ticks need a free output slot
	always_comb begin
		if (func == sbr_pkg::FuncByte) begin
			in_ready = slot_free || (pos_q != sbr_pkg::PosFooter);
		end else begin
			in_ready = slot_free || !(valid_q && tick_over);
		end
	end

	assign store_en   = accept && (func == sbr_pkg::FuncByte) &&
		(pos_q != sbr_pkg::PosIdle) && (pos_q != sbr_pkg::PosFooter);
	assign frame_emit = accept && (func == sbr_pkg::FuncByte) &&
		(pos_q == sbr_pkg::PosFooter) && footer_ok;
	assign tick_emit  = accept && (func == sbr_pkg::FuncTick) && valid_q && tick_over;

	// frame store chain: new bytes enter at the top and move down
	genvar gi;
	generate
		for (gi = 0; gi < SL; gi++) begin : g_store
			if (gi == SL - 1) begin : g_top
				sbr_byte_cell u_cell (
					.clk   (clk),
					.shift (store_en),
					.din   (rx_data),
					.dout  (store[gi])
				);
			end else begin : g_mid
				sbr_byte_cell u_cell (
					.clk   (clk),
					.shift (store_en),
					.din   (store[gi+1]),
					.dout  (store[gi])
				);
			end
		end
		for (gi = 0; gi < sbr_pkg::ChanBytes; gi++) begin : g_pack
			assign packed_bytes[gi*8 +: 8] = store[gi];
		end
	endgenerate

	// run chain control
	assign cell_ctrl.load  = frame_emit;
	assign cell_ctrl.shift = take;

	// channel cells hold the unpacked frame and shift toward cell zero
	generate
		for (gi = 0; gi < NCh; gi++) begin : g_chan
			if (gi == NCh - 1) begin : g_top
				sbr_chan_cell u_cell (
					.clk      (clk),
					.ctrl     (cell_ctrl),
					.load_val (packed_bytes[gi*CW +: CW]),
					.shift_in ('0),
					.dout     (chan[gi])
				);
			end else begin : g_mid
				sbr_chan_cell u_cell (
					.clk      (clk),
					.ctrl     (cell_ctrl),
					.load_val (packed_bytes[gi*CW +: CW]),
					.shift_in (chan[gi+1]),
					.dout     (chan[gi])
				);
			end
		end
	endgenerate

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= sbr_pkg::TimeoutReset;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= timeout_ticks;
		end
	end

	// byte position, link state and tick count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= sbr_pkg::PosIdle;
			valid_q <= 1'b0;
			ticks_q <= '0;
		end else if (accept) begin
			if (func == sbr_pkg::FuncTick) begin
				ticks_q <= ticks_next;
				if (tick_over) begin
					valid_q <= 1'b0;
				end
			end else if (pos_q == sbr_pkg::PosIdle) begin
				pos_q <= (rx_data == sbr_pkg::Header) ? sbr_pkg::PosW'(1) : sbr_pkg::PosIdle;
			end else if (pos_q == sbr_pkg::PosFooter) begin
				pos_q <= sbr_pkg::PosIdle;
				if (footer_ok) begin
					valid_q <= frame_ok;
					if (frame_ok) begin
						ticks_q <= '0;
					end
				end
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// output run counter and index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (frame_emit) begin
			rem_q <= sbr_pkg::RunLen;
			idx_q <= '0;
		end else if (tick_emit) begin
			rem_q <= sbr_pkg::RemW'(1);
			idx_q <= '0;
		end else if (take) begin
			rem_q <= rem_q - 1'b1;
			idx_q <= idx_q + 1'b1;
		end
	end

	// per-run result fields
	always_ff @(posedge clk) begin
		if (frame_emit) begin
			kind_q <= sbr_pkg::KindChannel;
			lost_q <= flag_lost;
			fs_q   <= flag_fs;
			ok_q   <= frame_ok;
		end else if (tick_emit) begin
			kind_q <= sbr_pkg::KindTimeout;
			lost_q <= 1'b0;
			fs_q   <= 1'b0;
			ok_q   <= 1'b0;
		end
	end

	// output port drive
	assign out_valid       = rem_q != '0;
	assign kind            = kind_q;
	assign channel_index   = idx_q;
	assign channel_value   = (kind_q == sbr_pkg::KindTimeout) ? '0 : chan[0];
	assign frame_lost_flag = lost_q;
	assign failsafe_flag   = fs_q;
	assign link_ok         = ok_q;
	assign last            = rem_q == sbr_pkg::RemW'(1);

`ifndef SYNTH
	// run counter never exceeds one frame
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= sbr_pkg::RunLen)
		else $error("run counter out of range");

	// no new run starts while more than the last result is pending
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q > sbr_pkg::RemW'(1)) |-> !(frame_emit || tick_emit))
		else $error("run loaded over pending results");

	// a good footer starts a full run at channel zero
	a_frame_run: assert property (@(posedge clk) disable iff (!arst_n)
		frame_emit |=> (rem_q == sbr_pkg::RunLen) && (idx_q == '0))
		else $error("frame run not started");

	// timeout results are single
	a_tick_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind_q == sbr_pkg::KindTimeout) |-> last)
		else $error("timeout result not last");

	// channel index advances by one within a run
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take && rem_q > sbr_pkg::RemW'(1) && !frame_emit && !tick_emit)
		|=> idx_q == $past(idx_q) + 4'd1)
		else $error("channel index skipped");
`endif

endmodule
